// ===== rtl/fiti_pkg.sv =====
package fiti_pkg;

  // Character codes recognised by the parser.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TICK  = 8'h27;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Width of the kept fraction digits (up to seven decimal digits).
  localparam int unsigned FRAC_DIG_W = 24;
  // Result magnitude width and result width.
  localparam int unsigned MAG_W = 47;
  localparam int unsigned VAL_W = 48;
  localparam logic [MAG_W-1:0] MAG_CAP = {MAG_W{1'b1}};

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_ZDEN = 2'd2;

  // Slot order of the four numbers of a string.
  localparam logic [1:0] SL_FEET = 2'd0;
  localparam logic [1:0] SL_INCH = 2'd1;
  localparam logic [1:0] SL_NUM  = 2'd2;
  localparam logic [1:0] SL_DEN  = 2'd3;

  typedef enum logic [3:0] {
    PS_START, PS_FIRST, PS_TICKED, PS_INCH2, PS_AFTER_INCH,
    PS_SLASHED, PS_NUMER, PS_DENOM, PS_DONE, PS_BAD
  } ps_e;

  typedef enum logic [2:0] {
    A_NONE, A_APPEND, A_SIGN, A_FEET, A_INCH, A_NUMER, A_DENOM
  } act_e;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CONV_GO, BK_CONV_WAIT, BK_DIV_GO, BK_DIV_WAIT,
    BK_FEET, BK_INCH, BK_FRAC, BK_OUT
  } bk_e;

  // Powers of ten used to scale kept fraction digits.
  function automatic logic [FRAC_DIG_W-1:0] pow10(input logic [2:0] n);
    logic [FRAC_DIG_W-1:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/fiti_fifo.sv =====
module fiti_fifo import fiti_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  // Two-entry queue: pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

// ===== rtl/fiti_div.sv =====
module fiti_div import fiti_pkg::*; #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   rem_sh, diff;

  // One restoring step: shift in the next dividend bit, try the subtract.
  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ~diff[DW]};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/fiti_front.sv =====
module fiti_front import fiti_pkg::*; #(
  parameter int unsigned INTEGER_BITS   = 24,
  parameter int unsigned DECIMAL_DIGITS = 6,
  parameter int unsigned JW = 2 + 4 * (INTEGER_BITS + FRAC_DIG_W + 3)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_code_i,
  output logic          push_o,
  output logic [JW-1:0] job_o,
  input  logic          full_i
);

  localparam int unsigned IW   = INTEGER_BITS;
  localparam int unsigned NUMW = IW + FRAC_DIG_W + 3;
  // All four slots cleared, with the denominator slot holding one.
  localparam logic [4*NUMW-1:0] SL_INIT = {IW'(1), (4*NUMW-IW)'(0)};

  typedef struct packed {
    logic [IW-1:0]         ip;
    logic [FRAC_DIG_W-1:0] fp;
    logic [2:0]            cnt;
  } num_t;

  typedef struct packed {
    logic       bad;
    logic       neg;
    num_t [3:0] num;
  } job_t;

  ps_e  ps_q, ps_d;
  act_e act;
  logic neg_q, neg_d;
  num_t cur_q, cur_d;
  logic [1:0] pt_q, pt_d;
  num_t [3:0] sl_q, sl_d;
  logic [7:0] c;
  logic numch, is_dig, fire, term;
  logic [3:0] dig;
  logic [IW+3:0] int10;
  logic [FRAC_DIG_W+3:0] frac10;
  job_t job;

  assign c      = char_code_i;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign numch  = is_dig || (c == CH_DOT);
  assign dig    = 4'(c - CH_ZERO);
  assign fire   = in_valid_i && in_ready_o;
  assign term   = c == CH_NUL;
  assign in_ready_o = !full_i;

  // Next parse state.
  always_comb begin
    ps_d = PS_BAD;
    case (ps_q)
      PS_START: begin
        if (numch) ps_d = PS_FIRST;
        else if (c == CH_MINUS || c == CH_PLUS) ps_d = PS_START;
      end
      PS_FIRST, PS_INCH2: begin
        if (numch) ps_d = ps_q;
        else if (c == CH_TICK && ps_q == PS_FIRST) ps_d = PS_TICKED;
        else if (c == CH_QUOTE || term) ps_d = PS_DONE;
        else if (c == CH_SPACE) ps_d = PS_AFTER_INCH;
        else if (c == CH_SLASH) ps_d = PS_SLASHED;
      end
      PS_TICKED: begin
        if (c == CH_SPACE) ps_d = PS_TICKED;
        else if (numch) ps_d = PS_INCH2;
        else if (term) ps_d = PS_DONE;
      end
      PS_AFTER_INCH: begin
        if (c == CH_SPACE) ps_d = PS_AFTER_INCH;
        else if (numch) ps_d = PS_NUMER;
        else if (term) ps_d = PS_DONE;
      end
      PS_NUMER: begin
        if (numch) ps_d = PS_NUMER;
        else if (c == CH_SLASH) ps_d = PS_SLASHED;
      end
      PS_SLASHED: begin
        if (numch) ps_d = PS_DENOM;
      end
      PS_DENOM: begin
        if (numch) ps_d = PS_DENOM;
        else if (c == CH_QUOTE || term) ps_d = PS_DONE;
      end
      PS_DONE: ps_d = PS_DONE;
      default: ps_d = PS_BAD;
    endcase
  end

  // Action taken on the current byte.
  always_comb begin
    act = A_NONE;
    case (ps_q)
      PS_START: begin
        if (numch) act = A_APPEND;
        else if (c == CH_MINUS || c == CH_PLUS) act = A_SIGN;
      end
      PS_FIRST, PS_INCH2: begin
        if (numch) act = A_APPEND;
        else if (c == CH_TICK && ps_q == PS_FIRST) act = A_FEET;
        else if (c == CH_QUOTE || term || c == CH_SPACE) act = A_INCH;
        else if (c == CH_SLASH) act = A_NUMER;
      end
      PS_TICKED, PS_AFTER_INCH, PS_SLASHED: begin
        if (c != CH_SPACE && numch) act = A_APPEND;
      end
      PS_NUMER: begin
        if (numch) act = A_APPEND;
        else if (c == CH_SLASH) act = A_NUMER;
      end
      PS_DENOM: begin
        if (numch) act = A_APPEND;
        else if (c == CH_QUOTE || term) act = A_DENOM;
      end
      default: act = A_NONE;
    endcase
  end

  // Digit accumulation and number capture.
  assign int10  = {4'd0, cur_q.ip} * (IW+4)'(10) + (IW+4)'(dig);
  assign frac10 = {4'd0, cur_q.fp} * (FRAC_DIG_W+4)'(10) + (FRAC_DIG_W+4)'(dig);

  always_comb begin
    cur_d = cur_q;
    pt_d  = pt_q;
    sl_d  = sl_q;
    neg_d = neg_q;
    case (act)
      A_APPEND: begin
        if (c == CH_DOT) begin
          pt_d = (pt_q == 2'd0) ? 2'd1 : 2'd2;
        end else if (pt_q == 2'd0) begin
          cur_d.ip = (int10 > (IW+4)'({IW{1'b1}})) ? {IW{1'b1}} : int10[IW-1:0];
        end else if (pt_q == 2'd1 && cur_q.cnt < 3'(DECIMAL_DIGITS)) begin
          cur_d.fp  = frac10[FRAC_DIG_W-1:0];
          cur_d.cnt = cur_q.cnt + 3'd1;
        end
      end
      A_SIGN: neg_d = c == CH_MINUS;
      A_FEET, A_INCH, A_NUMER, A_DENOM: begin
        case (act)
          A_FEET:  sl_d[SL_FEET] = cur_q;
          A_INCH:  sl_d[SL_INCH] = cur_q;
          A_NUMER: sl_d[SL_NUM]  = cur_q;
          default: sl_d[SL_DEN]  = cur_q;
        endcase
        cur_d = '0;
        pt_d  = 2'd0;
      end
      default: ;
    endcase
  end

  // The terminator hands the whole string to the back end.
  always_comb begin
    job.bad = ps_d != PS_DONE;
    job.neg = neg_q;
    job.num = sl_d;
  end

  assign push_o = fire && term;
  assign job_o  = JW'(job);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= PS_START;
      neg_q <= 1'b0;
      cur_q <= '0;
      pt_q  <= 2'd0;
      sl_q  <= SL_INIT;
    end else if (fire) begin
      if (term) begin
        ps_q  <= PS_START;
        neg_q <= 1'b0;
        cur_q <= '0;
        pt_q  <= 2'd0;
        sl_q  <= SL_INIT;
      end else begin
        ps_q  <= ps_d;
        neg_q <= neg_d;
        cur_q <= cur_d;
        pt_q  <= pt_d;
        sl_q  <= sl_d;
      end
    end
  end

endmodule

// ===== rtl/fiti_back.sv =====
module fiti_back import fiti_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned INTEGER_BITS  = 24,
  parameter int unsigned JW = 2 + 4 * (INTEGER_BITS + FRAC_DIG_W + 3)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [JW-1:0]     job_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VAL_W-1:0]  inches_value_o,
  output logic [1:0]        status_o
);

  localparam int unsigned IW = INTEGER_BITS;
  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned VW = IW + FB;
  localparam int unsigned DW = (VW > FRAC_DIG_W) ? VW : FRAC_DIG_W;
  localparam int unsigned NW = DW + FB;
  localparam int unsigned SW = NW + 52;

  typedef struct packed {
    logic [IW-1:0]         ip;
    logic [FRAC_DIG_W-1:0] fp;
    logic [2:0]            cnt;
  } num_t;

  typedef struct packed {
    logic       bad;
    logic       neg;
    num_t [3:0] num;
  } job_t;

  bk_e  st_q, st_d;
  job_t job_in, job_q;
  logic [1:0] k_q;
  logic [VW-1:0] val_q [4];
  logic [VW-1:0] new_val;
  logic [MAG_W-1:0] mag_q, frac_q, sat_w;
  logic [SW-1:0] sum_w, quot_w;
  logic [VAL_W-1:0] res_q;
  logic [1:0] stat_q;
  logic div_start, div_done, den_zero;
  logic [NW-1:0] div_num, div_quot;
  logic [DW-1:0] div_den;

  assign job_in = job_t'(job_i);

  fiti_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Fraction digits become fixed point below the integer part.
  assign new_val  = {job_q.num[k_q].ip, div_quot[FB-1:0]};
  assign den_zero = (k_q == SL_DEN) && (new_val == '0);

  // Divider operands: a digit conversion or the numerator over denominator.
  always_comb begin
    if (st_q == BK_CONV_GO) begin
      div_num = NW'({job_q.num[k_q].fp, {FB{1'b0}}});
      div_den = DW'(pow10(job_q.num[k_q].cnt));
    end else begin
      div_num = NW'({val_q[SL_NUM], {FB{1'b0}}});
      div_den = DW'(val_q[SL_DEN]);
    end
  end

  // Saturating adder shared by the three summing steps.
  assign quot_w = SW'(div_quot);
  always_comb begin
    case (st_q)
      BK_FEET: sum_w = (SW'(val_q[SL_FEET]) << 3) + (SW'(val_q[SL_FEET]) << 2);
      BK_INCH: sum_w = SW'(mag_q) + SW'(val_q[SL_INCH]);
      default: sum_w = SW'(mag_q) + SW'(frac_q);
    endcase
    sat_w = (sum_w > SW'(MAG_CAP)) ? MAG_CAP : sum_w[MAG_W-1:0];
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: begin
        if (!empty_i) st_d = job_in.bad ? BK_OUT : BK_CONV_GO;
      end
      BK_CONV_GO: st_d = BK_CONV_WAIT;
      BK_CONV_WAIT: begin
        if (div_done) begin
          if (k_q != SL_DEN) st_d = BK_CONV_GO;
          else if (den_zero) st_d = BK_OUT;
          else st_d = BK_DIV_GO;
        end
      end
      BK_DIV_GO: st_d = BK_DIV_WAIT;
      BK_DIV_WAIT: begin
        if (div_done) st_d = BK_FEET;
      end
      BK_FEET: st_d = BK_INCH;
      BK_INCH: st_d = BK_FRAC;
      BK_FRAC: st_d = BK_OUT;
      BK_OUT: begin
        if (out_ready_i) st_d = BK_IDLE;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o       = (st_q == BK_IDLE) && !empty_i;
    div_start   = (st_q == BK_CONV_GO) || (st_q == BK_DIV_GO);
    out_valid_o = st_q == BK_OUT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= BK_IDLE;
    else st_q <= st_d;
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        job_q  <= job_in;
        k_q    <= SL_FEET;
        res_q  <= '0;
        stat_q <= ST_BAD;
      end
      BK_CONV_WAIT: begin
        if (div_done) begin
          val_q[k_q] <= new_val;
          k_q        <= k_q + 2'd1;
          stat_q     <= ST_ZDEN;
        end
      end
      BK_DIV_WAIT: begin
        if (div_done) frac_q <= (quot_w > SW'(MAG_CAP)) ? MAG_CAP : quot_w[MAG_W-1:0];
      end
      BK_FEET, BK_INCH: mag_q <= sat_w;
      BK_FRAC: begin
        res_q  <= job_q.neg ? -{1'b0, sat_w} : {1'b0, sat_w};
        stat_q <= ST_OK;
      end
      default: ;
    endcase
  end

  assign inches_value_o = res_q;
  assign status_o       = stat_q;

endmodule

// ===== rtl/feet_inch_text_to_inches.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | char_code_i (8 bits)
// out     | output    | out_valid_o/out_ready_i | inches_value_o (48, signed), status_o
//
// Ordinary bytes are taken one per cycle while the job queue has room.
// A zero byte queues the string; the back end then works through it with the
// bit-serial divider, which converts four numbers and forms the fraction.
// Reset returns both parts to their idle state and empties the queue.
// The front stalls only when two finished strings already wait in the queue.
module feet_inch_text_to_inches import fiti_pkg::*; #(
  parameter int unsigned FRACTION_BITS  = 16,
  parameter int unsigned INTEGER_BITS   = 24,
  parameter int unsigned DECIMAL_DIGITS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_code_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [VAL_W-1:0] inches_value_o,
  output logic [1:0]       status_o
);

  localparam int unsigned JW = 2 + 4 * (INTEGER_BITS + FRAC_DIG_W + 3);

  logic          push, pop, full, empty;
  logic [JW-1:0] job_in, job_out;

  fiti_front #(
    .INTEGER_BITS  (INTEGER_BITS),
    .DECIMAL_DIGITS(DECIMAL_DIGITS),
    .JW            (JW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  fiti_fifo #(.WIDTH(JW)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .full_o (full),
    .empty_o(empty)
  );

  fiti_back #(
    .FRACTION_BITS(FRACTION_BITS),
    .INTEGER_BITS (INTEGER_BITS),
    .JW           (JW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .inches_value_o(inches_value_o),
    .status_o      (status_o)
  );

endmodule

// ===== tb/fiti_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts each length result and compares it.
module fiti_checker import fiti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       char_code_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [VAL_W-1:0] inches_value_i,
  input  logic [1:0]       status_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned INT_BITS  = 24;
  localparam int unsigned KEEP_DIGS = 6;
  localparam longint unsigned INT_LIMIT = (64'd1 << INT_BITS) - 1;
  localparam longint unsigned CAP = (64'd1 << 47) - 1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
  } length_t;

  length_t         lengths_due[$];
  ps_e             st;
  bit              neg;
  longint unsigned int_part, frac_part, feet, inch, numer, denom;
  int unsigned     frac_cnt, dots;

  function automatic longint unsigned ten_pow(input int unsigned n);
    longint unsigned p;
    p = 1;
    repeat (n) p = p * 10;
    return p;
  endfunction

  function automatic void clear_all();
    st = PS_START;
    neg = 0;
    int_part = 0; frac_part = 0; frac_cnt = 0; dots = 0;
    feet = 0; inch = 0; numer = 0;
    denom = 64'd1 << FRAC_BITS;
  endfunction

  function automatic void add_char(input logic [7:0] c);
    longint unsigned v;
    if (c == CH_DOT) begin
      dots = (dots == 0) ? 1 : 2;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (dots == 0) begin
        v = int_part * 10 + (c - CH_ZERO);
        int_part = (v > INT_LIMIT) ? INT_LIMIT : v;
      end else if (dots == 1 && frac_cnt < KEEP_DIGS) begin
        frac_part = frac_part * 10 + (c - CH_ZERO);
        frac_cnt++;
      end
    end
  endfunction

  function automatic longint unsigned close_number();
    longint unsigned v;
    v = (int_part << FRAC_BITS) + ((frac_part << FRAC_BITS) / ten_pow(frac_cnt));
    int_part = 0; frac_part = 0; frac_cnt = 0; dots = 0;
    return v;
  endfunction

  function automatic longint unsigned sat_sum(input longint unsigned a, b);
    return (a + b > CAP) ? CAP : a + b;
  endfunction

  // Long division giving FRAC_BITS fraction bits, saturated.
  function automatic longint unsigned ratio(input longint unsigned n, d);
    longint unsigned q, r;
    q = n / d;
    r = n % d;
    if (q > (CAP >> FRAC_BITS)) return CAP;
    repeat (FRAC_BITS) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return (q > CAP) ? CAP : q;
  endfunction

  // Advances the parser by one byte; a zero byte queues the expected length.
  function automatic void parse_byte(input logic [7:0] c);
    bit      num;
    ps_e     nx;
    act_e    a;
    length_t res;
    longint unsigned mag;
    num = (c >= CH_ZERO && c <= CH_NINE) || c == CH_DOT;
    nx = PS_BAD;
    a = A_NONE;
    case (st)
      PS_START: begin
        if (num) begin nx = PS_FIRST; a = A_APPEND; end
        else if (c == CH_MINUS || c == CH_PLUS) begin nx = PS_START; a = A_SIGN; end
      end
      PS_FIRST, PS_INCH2: begin
        if (num) begin nx = st; a = A_APPEND; end
        else if (c == CH_TICK && st == PS_FIRST) begin nx = PS_TICKED; a = A_FEET; end
        else if (c == CH_QUOTE || c == CH_NUL) begin nx = PS_DONE; a = A_INCH; end
        else if (c == CH_SPACE) begin nx = PS_AFTER_INCH; a = A_INCH; end
        else if (c == CH_SLASH) begin nx = PS_SLASHED; a = A_NUMER; end
      end
      PS_TICKED: begin
        if (c == CH_SPACE) nx = PS_TICKED;
        else if (num) begin nx = PS_INCH2; a = A_APPEND; end
        else if (c == CH_NUL) nx = PS_DONE;
      end
      PS_AFTER_INCH: begin
        if (c == CH_SPACE) nx = PS_AFTER_INCH;
        else if (num) begin nx = PS_NUMER; a = A_APPEND; end
        else if (c == CH_NUL) nx = PS_DONE;
      end
      PS_NUMER: begin
        if (num) begin nx = PS_NUMER; a = A_APPEND; end
        else if (c == CH_SLASH) begin nx = PS_SLASHED; a = A_NUMER; end
      end
      PS_SLASHED: begin
        if (num) begin nx = PS_DENOM; a = A_APPEND; end
      end
      PS_DENOM: begin
        if (num) begin nx = PS_DENOM; a = A_APPEND; end
        else if (c == CH_QUOTE || c == CH_NUL) begin nx = PS_DONE; a = A_DENOM; end
      end
      PS_DONE: nx = PS_DONE;
      default: nx = PS_BAD;
    endcase
    case (a)
      A_APPEND: add_char(c);
      A_SIGN:   neg = (c == CH_MINUS);
      A_FEET:   feet = close_number();
      A_INCH:   inch = close_number();
      A_NUMER:  numer = close_number();
      A_DENOM:  denom = close_number();
      default: ;
    endcase
    st = nx;
    if (c != CH_NUL) return;
    mag = 0;
    if (st != PS_DONE) begin
      res.status = ST_BAD;
    end else if (denom == 0) begin
      res.status = ST_ZDEN;
    end else begin
      res.status = ST_OK;
      mag = feet * 12;
      if (mag > CAP) mag = CAP;
      mag = sat_sum(mag, inch);
      mag = sat_sum(mag, ratio(numer, denom));
      if (neg) mag = -mag;
    end
    res.value = mag[VAL_W-1:0];
    lengths_due.push_back(res);
    clear_all();
  endfunction

  assign pending_o = lengths_due.size();

  // Predict on every input beat, check on every output beat.
  always @(posedge clk_i or negedge rst_ni) begin
    length_t want;
    if (!rst_ni) begin
      clear_all();
      lengths_due.delete();
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(char_code_i);
      if (out_valid_i && out_ready_i) begin
        results_o <= results_o + 1;
        if (lengths_due.size() == 0) begin
          $display("%0t: unexpected result value=%h status=%0d",
                   $time, inches_value_i, status_i);
          errors_o <= errors_o + 1;
        end else begin
          want = lengths_due.pop_front();
          if (want.value !== inches_value_i || want.status !== status_i) begin
            $display("%0t: mismatch value exp=%h got=%h status exp=%0d got=%0d",
                     $time, want.value, inches_value_i, want.status, status_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

// Drives length strings into the parser and gives the verdict.
module tb_top;
  import fiti_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       char_code_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [VAL_W-1:0] inches_value_o;
  logic [1:0]       status_o;

  int  errors, pending, results;
  int  beats_sent, strings_sent;
  bit  steady;
  byte unsigned text_q[$];

  feet_inch_text_to_inches uut (.*);

  fiti_checker lengths_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .char_code_i,
    .out_valid_i(out_valid_o), .out_ready_i, .inches_value_i(inches_value_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver stalls now and then, except during the steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 7);
  end

  // Sends one byte, with an occasional gap before it.
  task automatic send_beat(input byte unsigned b);
    while (!steady && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // Sends the queued text followed by the terminating zero byte.
  task automatic send_text();
    text_q.push_back(CH_NUL);
    foreach (text_q[i]) send_beat(text_q[i]);
    text_q.delete();
    strings_sent++;
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Random decimal number: mostly short, sometimes long or with extra points.
  task automatic put_number();
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(12, 6) : $urandom_range(3, 1);
    repeat (n) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
    if ($urandom_range(3) == 0) begin
      text_q.push_back(CH_DOT);
      repeat ($urandom_range(8)) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      if ($urandom_range(7) == 0) begin
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(2)) text_q.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    end
  endtask

  // Well-formed length with random parts present or absent.
  task automatic put_length();
    repeat ($urandom_range(2)) text_q.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
    put_number();
    if ($urandom_range(1)) begin
      text_q.push_back(CH_TICK);
      repeat ($urandom_range(2)) text_q.push_back(CH_SPACE);
      if ($urandom_range(3) == 0) return;
      put_number();
    end
    case ($urandom_range(3))
      0: ;
      1: text_q.push_back(CH_QUOTE);
      default: begin
        text_q.push_back(CH_SPACE);
        put_number();
        text_q.push_back(CH_SLASH);
        if ($urandom_range(15) == 0) put_str("0"); else put_number();
        if ($urandom_range(1)) text_q.push_back(CH_QUOTE);
      end
    endcase
  endtask

  initial begin
    in_valid_i  = 1'b0;
    char_code_i = '0;
    steady      = 1'b0;
    beats_sent  = 0;
    strings_sent = 0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: empty, signs, saturation, points, cut-off, bad bytes.
    send_text();
    put_str("-5' 3 1/2\""); send_text();
    put_str("+-+12\""); send_text();
    put_str("-"); send_text();
    put_str("999999999' 99999999 99999999/0.000001\""); send_text();
    put_str("1.2.3\""); send_text();
    put_str("1.12345678\""); send_text();
    put_str("5'   7"); send_text();
    put_str("5'"); send_text();
    put_str("3 1/0\""); send_text();
    put_str("3 1/"); send_text();
    put_str("3 4"); send_text();
    put_str("1 2/3/4\""); send_text();
    put_str("7\"xyz"); text_q.push_back(8'hFF); send_text();
    text_q.push_back(8'h80); send_text();
    put_str("12 "); send_text();
    put_str(".5/.25"); send_text();
    put_str("2'x"); send_text();

    // Hold off until the parser has drained everything.
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);

    // Random strings: mostly well formed, some noise and broken ones.
    while (beats_sent < 1150) begin
      steady = (beats_sent > 500 && beats_sent < 650);
      case ($urandom_range(9))
        0: repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255, 1)));
        1: begin
          put_length();
          if (text_q.size() > 1) text_q.delete(text_q.size() - 1);
        end
        default: put_length();
      endcase
      send_text();
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d strings in %0d bytes, checked %0d results.",
             strings_sent, beats_sent, results);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out with %0d results outstanding.", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
